>>> rtl/core/wsdfr_pkg.sv
package wsdfr_pkg;

  // Header parse phases.
  typedef enum logic [2:0] {
    PH_B0  = 3'd0,
    PH_B1  = 3'd1,
    PH_EXT = 3'd2,
    PH_KEY = 3'd3,
    PH_PAY = 3'd4
  } phase_e;

  // Header constants.
  localparam logic [7:0] FinMask    = 8'h80;
  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] Len7Mask   = 8'h7F;
  localparam logic [6:0] Len16Code  = 7'd126;
  localparam logic [6:0] Len64Code  = 7'd127;
  localparam logic [3:0] Len16Bytes = 4'd2;
  localparam logic [3:0] Len64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // Width of the packed result data bus.
  localparam int unsigned ResDataW = 80;

  // One result transaction.
  typedef struct packed {
    logic        last;
    logic        header_truncated;
    logic [63:0] declared_length;
    logic        was_masked;
    logic [3:0]  frame_opcode;
    logic        fin_bit;
    logic        byte_valid;
    logic [7:0]  payload_byte;
  } res_t;

  // Pick key byte i mod 4; the first key byte received sits in bits 31..24.
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [4:0] lsb;
    lsb = {2'd3 - pos, 3'b000};
    return key[lsb +: 8];
  endfunction

endpackage

>>> rtl/core/wsdfr_parser.sv
module wsdfr_parser
  import wsdfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       eob_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  phase_e      hdr_phase;
  logic [3:0]  left_dec;
  logic [6:0]  len7;

  assign left_dec = left_q - 4'd1;
  assign len7     = in_byte_i[6:0] & Len7Mask[6:0];

  // Header field update and payload unmasking for one byte.
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    left_d    = left_q;
    key_d     = key_q;
    pos_d     = pos_q;
    hdr_phase = phase_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_PAY: begin
        pos_d = pos_q + 2'd1;
        if (eob_i) begin
          phase_d = PH_B0;
        end
      end
      PH_B1: begin
        mask_d = (in_byte_i & FinMask) != 8'd0;
        if (len7 == Len16Code) begin
          hdr_phase = PH_EXT;
          left_d    = Len16Bytes;
          len_d     = '0;
        end else if (len7 == Len64Code) begin
          hdr_phase = PH_EXT;
          left_d    = Len64Bytes;
          len_d     = '0;
        end else begin
          len_d = {57'd0, len7};
          if (mask_d) begin
            hdr_phase = PH_KEY;
            left_d    = KeyBytes;
          end else begin
            hdr_phase = PH_PAY;
          end
        end
      end
      PH_EXT: begin
        len_d  = {len_q[55:0], in_byte_i};
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          if (mask_q) begin
            hdr_phase = PH_KEY;
            left_d    = KeyBytes;
          end else begin
            hdr_phase = PH_PAY;
          end
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], in_byte_i};
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          hdr_phase = PH_PAY;
        end
      end
      default: begin
        fin_d     = (in_byte_i & FinMask) != 8'd0;
        opcode_d  = in_byte_i[3:0] & OpcodeMask[3:0];
        mask_d    = 1'b0;
        len_d     = '0;
        key_d     = '0;
        pos_d     = 2'd0;
        left_d    = 4'd0;
        hdr_phase = PH_B1;
      end
    endcase

    res_o.fin_bit         = fin_d;
    res_o.frame_opcode    = opcode_d;
    res_o.was_masked      = mask_d;
    res_o.declared_length = len_d;
    res_o.last            = eob_i;

    if (phase_q == PH_PAY) begin
      // Payload byte: always a result.
      res_valid_o        = 1'b1;
      res_o.byte_valid   = 1'b1;
      res_o.payload_byte = mask_q ? (in_byte_i ^ key_byte(key_q, pos_q)) : in_byte_i;
    end else begin
      // Header byte: a result only when the buffer ends here.
      phase_d = hdr_phase;
      if (eob_i) begin
        res_valid_o            = 1'b1;
        res_o.header_truncated = (hdr_phase != PH_PAY);
        phase_d                = PH_B0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      fin_q    <= 1'b0;
      opcode_q <= 4'd0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      left_q   <= 4'd0;
      key_q    <= '0;
      pos_q    <= 2'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      left_q   <= left_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

endmodule

>>> rtl/core/wsdfr_outbuf.sv
module wsdfr_outbuf
  import wsdfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t res_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  // Output slot refills from the skid slot first, then from the parser.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

>>> rtl/core/websocket_frame_deframer.sv
// Receive-side WebSocket frame parser. Takes one buffer byte per transaction
// and sustains one byte per clock cycle: the header fields and the payload
// unmasking XOR are updated combinationally, and a two-entry output buffer
// (output register plus skid register) keeps input and output apart, so input
// stalls only when both entries hold results. Header bytes give no output
// except on the final byte of a buffer, which yields an empty or truncated
// result; each payload byte gives one output carrying the header fields.
// Each result is registered in the output buffer before it reaches the master side.
module websocket_frame_deframer
  import wsdfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] in_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] payload_byte, [8] fin_bit, [12:9] frame_opcode, [13] was_masked,
  // [77:14] declared_length, [79:78] zero
  output logic [ResDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser,  // [0] byte_valid, [1] header_truncated
  output logic                m_axis_tlast
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign accept = s_axis_tvalid & s_axis_tready;

  wsdfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (s_axis_tdata),
    .eob_i      (s_axis_tlast),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsdfr_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept & res_valid),
    .res_i      (res),
    .ready_o    (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .pop_ready_i(m_axis_tready),
    .res_o      (out_res)
  );

  // Pack the result onto the master side.
  assign m_axis_tdata = {2'b00, out_res.declared_length, out_res.was_masked,
                         out_res.frame_opcode, out_res.fin_bit, out_res.payload_byte};
  assign m_axis_tuser = {out_res.header_truncated, out_res.byte_valid};
  assign m_axis_tlast = out_res.last;

`ifndef SYNTH
  // Input stalls only when a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // A truncated header never carries data and always closes the buffer.
  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("truncated header result malformed");

  // An empty result has a zero data byte and ends the buffer.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
    else $error("empty result malformed");
`endif

endmodule

>>> sim/websocket_frame_deframer_test.sv
module websocket_frame_deframer_test;
  import wsdfr_pkg::*;

  // One received byte as it waits to be offered on the input stream.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } rx_byte_t;

  localparam int unsigned ByteTarget = 1250;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldAfter  = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ResDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  websocket_frame_deframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bytes still to be sent and deframed results still to arrive.
  rx_byte_t tx_bytes_q [$];
  res_t     due_results [$];

  int unsigned errors = 0;
  int unsigned offered = 0;
  int unsigned bytes_in = 0;
  int unsigned results_out = 0;
  int unsigned data_results = 0;
  int unsigned empty_results = 0;
  int unsigned trunc_results = 0;
  int unsigned frames_built = 0;
  int unsigned headers_cut = 0;
  int unsigned idle_cycles = 0;

  // Parser state as the testbench tracks it.
  phase_e      rx_phase = PH_B0;
  logic        fin_q = 1'b0;
  logic [3:0]  opc_q = '0;
  logic        mask_q = 1'b0;
  logic [63:0] len_q = '0;
  logic [3:0]  field_left = '0;
  logic [31:0] key_q = '0;
  logic [1:0]  key_pos_q = '0;

  // The length is known: go on to the masking key or straight to the payload.
  task automatic length_done();
    if (mask_q) begin
      rx_phase   = PH_KEY;
      field_left = KeyBytes;
    end else begin
      rx_phase = PH_PAY;
    end
  endtask

  // Advance the tracked parser by one accepted byte and queue its result, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    res_t r;
    logic gives;
    logic [6:0] len7;
    r    = '0;
    gives = 1'b0;
    len7 = 7'(b & Len7Mask);
    if (rx_phase == PH_PAY) begin
      r.payload_byte = mask_q ? (b ^ key_q[8 * (3 - int'(key_pos_q)) +: 8]) : b;
      r.byte_valid   = 1'b1;
      key_pos_q      = key_pos_q + 2'd1;
      gives          = 1'b1;
    end else begin
      case (rx_phase)
        PH_B1: begin
          mask_q = b[7];
          if (len7 == Len16Code) begin
            rx_phase   = PH_EXT;
            field_left = Len16Bytes;
            len_q      = '0;
          end else if (len7 == Len64Code) begin
            rx_phase   = PH_EXT;
            field_left = Len64Bytes;
            len_q      = '0;
          end else begin
            len_q = 64'(len7);
            length_done();
          end
        end
        PH_EXT: begin
          len_q      = {len_q[55:0], b};
          field_left = field_left - 4'd1;
          if (field_left == '0) length_done();
        end
        PH_KEY: begin
          key_q      = {key_q[23:0], b};
          field_left = field_left - 4'd1;
          if (field_left == '0) rx_phase = PH_PAY;
        end
        default: begin
          fin_q      = (b & FinMask) != '0;
          opc_q      = 4'(b & OpcodeMask);
          mask_q     = 1'b0;
          len_q      = '0;
          key_q      = '0;
          key_pos_q  = '0;
          field_left = '0;
          rx_phase   = PH_B1;
        end
      endcase
      if (eob) begin
        // Buffer ended in or right at the end of the header.
        r.header_truncated = (rx_phase != PH_PAY);
        gives = 1'b1;
      end
    end
    if (gives) begin
      r.fin_bit         = fin_q;
      r.frame_opcode    = opc_q;
      r.was_masked      = mask_q;
      r.declared_length = len_q;
      r.last            = eob;
      due_results = {due_results, r};
      if (eob) rx_phase = PH_B0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Queue one buffer; its final byte carries the end-of-buffer flag.
  task automatic queue_buffer(input logic [7:0] seq [$]);
    foreach (seq[i]) tx_bytes_q = {tx_bytes_q, rx_byte_t'{seq[i], i == seq.size() - 1}};
  endtask

  // A random frame with random content, now and then cut off inside the header.
  task automatic add_random_frame();
    logic [7:0]  fr [$];
    logic [63:0] len64;
    logic        masked;
    int          n_pay;
    int          hdr_len;
    int          cut;
    masked = ($urandom_range(0, 3) != 0);
    n_pay  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                         : int'($urandom_range(0, 12));
    len64  = ($urandom_range(0, 1) == 0) ? 64'(n_pay) : {$urandom, $urandom};
    fr = {fr, 8'($urandom)};
    case ($urandom_range(0, 2))
      0: begin
        if (len64 > 64'd125) len64 = 64'($urandom_range(0, 125));
        fr = {fr, {masked, len64[6:0]}};
      end
      1: begin
        fr = {fr, {masked, Len16Code}};
        fr = {fr, len64[15:8]};
        fr = {fr, len64[7:0]};
      end
      default: begin
        fr = {fr, {masked, Len64Code}};
        for (int i = 7; i >= 0; i--) fr = {fr, len64[8 * i +: 8]};
      end
    endcase
    if (masked) repeat (4) fr = {fr, 8'($urandom)};
    hdr_len = fr.size();
    frames_built++;
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, hdr_len - 2);
      fr  = fr[0:cut];
      headers_cut++;
    end else begin
      repeat (n_pay) fr = {fr, 8'($urandom)};
    end
    queue_buffer(fr);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  always @(negedge clk_i) begin
    rx_byte_t nxt;
    if (rst_ni && offered == bytes_in) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (tx_bytes_q.size() > 0) begin
        nxt = tx_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.eob;
        offered++;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          gap_left   = 0;
          burst_left = $urandom_range(80, 250);
        end else begin
          gap_left   = $urandom_range(1, 6);
          burst_left = $urandom_range(1, 24);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern that steps through four modes in turn, plus one long hold-off.
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    logic rdy;
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && results_out >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      rdy = 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 0);
        2: rdy = (rx_cycle % 3 == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
    end
    m_axis_tready <= rdy;
  end

  // Monitor: deframe accepted bytes, check accepted results, watch for a hang.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata, s_axis_tlast);
        bytes_in++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        results_out++;
        got.payload_byte     = m_axis_tdata[7:0];
        got.byte_valid       = m_axis_tuser[0];
        got.fin_bit          = m_axis_tdata[8];
        got.frame_opcode     = m_axis_tdata[12:9];
        got.was_masked       = m_axis_tdata[13];
        got.declared_length  = m_axis_tdata[77:14];
        got.header_truncated = m_axis_tuser[1];
        got.last             = m_axis_tlast;
        if (got.byte_valid) data_results++;
        else if (got.header_truncated) trunc_results++;
        else empty_results++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
          check_field("byte_valid", 64'(want.byte_valid), 64'(got.byte_valid));
          check_field("fin_bit", 64'(want.fin_bit), 64'(got.fin_bit));
          check_field("frame_opcode", 64'(want.frame_opcode), 64'(got.frame_opcode));
          check_field("was_masked", 64'(want.was_masked), 64'(got.was_masked));
          check_field("declared_length", want.declared_length, got.declared_length);
          check_field("header_truncated", 64'(want.header_truncated),
                      64'(got.header_truncated));
          check_field("last", 64'(want.last), 64'(got.last));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] seq [$];
    // Unmasked frame: bytes pass through, extremes of the byte value.
    seq = '{8'h81, 8'h02, 8'h00, 8'hFF};
    queue_buffer(seq);
    // Masked frame with a 16-bit length; the key wraps after four bytes.
    seq = '{8'h82, 8'hFE, 8'h00, 8'h05, 8'hAA, 8'h55, 8'h0F, 8'hF0,
            8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
    queue_buffer(seq);
    // Buffer ends right after the first header byte, reserved bits set.
    seq = '{8'hFF};
    queue_buffer(seq);
    // Buffer ends inside a 64-bit length: partial length is reported.
    seq = '{8'h09, 8'h7F, 8'hFF, 8'hAB};
    queue_buffer(seq);
    // Header completes on the final byte: empty payload.
    seq = '{8'h8A, 8'h00};
    queue_buffer(seq);
    frames_built = 5;
    headers_cut  = 2;
    while (tx_bytes_q.size() < ByteTarget) add_random_frame();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(tx_bytes_q.size() == 0 && offered == bytes_in && due_results.size() == 0))
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
      errors += due_results.size();
    end

    $display("Sent %0d frames in %0d bytes, %0d of them cut off inside the header.",
             frames_built, bytes_in, headers_cut);
    $display("Checked %0d results: %0d payload bytes, %0d empty, %0d truncated.",
             results_out, data_results, empty_results, trunc_results);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
